@@ rtl/chdec_pkg.sv @@
// ----------------------------------------------------------------------------
// chdec_pkg
// Shared types and constants of the chunked body decoder: decode phases,
// end status codes, size line prefix progress, byte class and result word.
// ----------------------------------------------------------------------------
package chdec_pkg;

   // line terminator characters
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // hex digit width of the size line
   localparam int unsigned DIGIT_BITS = 4;

   // decode phase
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_SIZE = 3'd1,
      PH_TAIL = 3'd2,
      PH_DATA = 3'd3,
      PH_SKIP = 3'd4,
      PH_DONE = 3'd5
   } phase_type;

   // end status codes
   typedef enum logic [2:0] {
      ST_ZERO_CHUNK = 3'd0,
      ST_BOUNDARY   = 3'd1,
      ST_IN_LINE    = 3'd2,
      ST_EXCEEDS    = 3'd3,
      ST_NO_DIGITS  = 3'd4
   } end_status_type;

   // size line prefix progress
   typedef enum logic [1:0] {
      PFX_START  = 2'd0,
      PFX_ZERO   = 2'd1,
      PFX_X      = 2'd2,
      PFX_DIGITS = 2'd3
   } prefix_type;

   // byte class worked out by the front part
   typedef struct packed {
      logic                  is_hex;
      logic [DIGIT_BITS-1:0] hex_val;
      logic                  is_blank;
      logic                  is_cr;
      logic                  is_lf;
      logic                  is_zero;
      logic                  is_x;
   } byte_class_type;

   localparam int unsigned CLASS_BITS = $bits(byte_class_type);

   // one result word
   typedef struct packed {
      logic [7:0]     out_byte;
      logic           byte_valid;
      logic           end_of_message;
      end_status_type end_status;
   } result_type;

endpackage

@@ rtl/chdec_front.sv @@
// ----------------------------------------------------------------------------
// chdec_front
// Input side: takes body bytes, classifies each one and pushes the
// classified word into the queue.
// ----------------------------------------------------------------------------
module chdec_front
   import chdec_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 24,
   parameter int unsigned ITEM_BITS   = CLASS_BITS + 8 + 2 + LENGTH_BITS
) (
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_first_byte,
   input  logic                   req_last_byte,
   input  logic [LENGTH_BITS-1:0] req_body_length,
   input  logic                   q_full,
   output logic                   q_push,
   output logic [ITEM_BITS-1:0]   q_item
);

   byte_class_type cls;

   // character classes of the size line
   always_comb begin
      cls          = '0;
      cls.is_blank = (req_data_byte == 8'h20) ||
                     (req_data_byte >= 8'h09 && req_data_byte <= 8'h0D);
      cls.is_cr    = (req_data_byte == CHAR_CR);
      cls.is_lf    = (req_data_byte == CHAR_LF);
      cls.is_zero  = (req_data_byte == 8'h30);
      cls.is_x     = (req_data_byte == 8'h78) || (req_data_byte == 8'h58);
      if (req_data_byte >= 8'h30 && req_data_byte <= 8'h39) begin
         cls.is_hex  = 1'b1;
         cls.hex_val = req_data_byte[DIGIT_BITS-1:0];
      end else if (req_data_byte >= 8'h61 && req_data_byte <= 8'h66) begin
         cls.is_hex  = 1'b1;
         cls.hex_val = DIGIT_BITS'(req_data_byte - 8'h57);
      end else if (req_data_byte >= 8'h41 && req_data_byte <= 8'h46) begin
         cls.is_hex  = 1'b1;
         cls.hex_val = DIGIT_BITS'(req_data_byte - 8'h37);
      end
   end

   // handshake and packing
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign q_item    = {cls, req_data_byte, req_first_byte, req_last_byte, req_body_length};

endmodule

@@ rtl/chdec_queue.sv @@
// ----------------------------------------------------------------------------
// chdec_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module chdec_queue #(
   parameter int unsigned WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic             full,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign head_data = entry_ff[rd_ptr_ff];

endmodule

@@ rtl/chdec_back.sv @@
// ----------------------------------------------------------------------------
// chdec_back
// Decode side: runs the chunk state over classified bytes from the queue
// and holds each result word in the output register.
// ----------------------------------------------------------------------------
module chdec_back
   import chdec_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 24,
   parameter int unsigned ITEM_BITS   = CLASS_BITS + 8 + 2 + LENGTH_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  logic [ITEM_BITS-1:0] q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output result_type           rsp_word
);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   // unpacked queue head
   byte_class_type         it_cls;
   logic [7:0]             it_byte;
   logic                   it_first;
   logic                   it_last;
   logic [LENGTH_BITS-1:0] it_len;

   // decode state
   phase_type              phase_ff,  phase_in;
   logic [LENGTH_BITS-1:0] pos_ff,    pos_in;
   logic [LENGTH_BITS-1:0] len_ff,    len_in;
   logic [LENGTH_BITS-1:0] acc_ff,    acc_in;
   logic                   ovf_ff,    ovf_in;
   logic                   digit_ff,  digit_in;
   prefix_type             pfx_ff,    pfx_in;
   logic                   pcr_ff,    pcr_in;
   logic [LENGTH_BITS-1:0] drem_ff,   drem_in;
   logic [1:0]             srem_ff,   srem_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_word_ff,  rsp_word_in;

   // state as seen by this word, after a restart on first
   phase_type              cur_phase;
   logic [LENGTH_BITS-1:0] cur_pos;
   logic [LENGTH_BITS-1:0] cur_len;
   logic [LENGTH_BITS-1:0] cur_acc;
   logic                   cur_ovf;
   logic                   cur_digit;
   prefix_type             cur_pfx;
   logic                   cur_pcr;
   logic [LENGTH_BITS-1:0] cur_drem;
   logic [1:0]             cur_srem;

   logic [LENGTH_BITS-1:0] pos_next;
   logic                   fin;
   logic [LENGTH_BITS-1:0] bytes_left;
   logic                   too_big;
   logic [LENGTH_BITS-1:0] drem_dec;
   logic [1:0]             srem_dec;
   logic [LENGTH_BITS-1:0] acc_shift;
   logic                   acc_carry;
   phase_type              ph_mid;
   logic                   ended;
   logic                   valid;
   end_status_type         status;

   assign {it_cls, it_byte, it_first, it_last, it_len} = q_item;

   // pop when the output register is free or being drained
   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_ready);

   // restart on the first byte of a body
   always_comb begin
      if (it_first) begin
         cur_phase = PH_SIZE;
         cur_pos   = '0;
         cur_len   = it_len;
         cur_acc   = '0;
         cur_ovf   = 1'b0;
         cur_digit = 1'b0;
         cur_pfx   = PFX_START;
         cur_pcr   = 1'b0;
         cur_drem  = '0;
         cur_srem  = 2'd0;
      end else begin
         cur_phase = phase_ff;
         cur_pos   = pos_ff;
         cur_len   = len_ff;
         cur_acc   = acc_ff;
         cur_ovf   = ovf_ff;
         cur_digit = digit_ff;
         cur_pfx   = pfx_ff;
         cur_pcr   = pcr_ff;
         cur_drem  = drem_ff;
         cur_srem  = srem_ff;
      end
   end

   // position, body end and bytes left
   assign pos_next   = (cur_pos != LEN_MAX) ? cur_pos + 1'b1 : cur_pos;
   assign fin        = it_last || (pos_next >= cur_len);
   assign bytes_left = cur_len - pos_next;
   assign too_big    = fin || (cur_acc > bytes_left);
   assign drem_dec   = (cur_drem != '0) ? cur_drem - 1'b1 : cur_drem;
   assign srem_dec   = (cur_srem != 2'd0) ? cur_srem - 2'd1 : cur_srem;
   assign acc_shift  = {cur_acc[LENGTH_BITS-DIGIT_BITS-1:0], it_cls.hex_val};
   assign acc_carry  = |cur_acc[LENGTH_BITS-1:LENGTH_BITS-DIGIT_BITS];

   // next state and result
   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      digit_in     = digit_ff;
      pfx_in       = pfx_ff;
      pcr_in       = pcr_ff;
      drem_in      = drem_ff;
      srem_in      = srem_ff;
      ph_mid       = cur_phase;
      ended        = 1'b0;
      valid        = 1'b0;
      status       = ST_ZERO_CHUNK;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;

      if (q_pop) begin
         phase_in = cur_phase;
         pos_in   = cur_pos;
         len_in   = cur_len;
         acc_in   = cur_acc;
         ovf_in   = cur_ovf;
         digit_in = cur_digit;
         pfx_in   = cur_pfx;
         pcr_in   = cur_pcr;
         drem_in  = cur_drem;
         srem_in  = cur_srem;

         case (cur_phase)
            PH_IDLE: begin
               // dropped
            end
            PH_DONE: begin
               if (it_last) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_SIZE, PH_TAIL: begin
               pos_in = pos_next;
               if (cur_pcr && it_cls.is_lf) begin
                  // line end: check the size
                  pcr_in = 1'b0;
                  ended  = 1'b1;
                  if (!cur_digit) begin
                     status = ST_NO_DIGITS;
                  end else if (cur_ovf) begin
                     status = ST_EXCEEDS;
                  end else if (cur_acc == '0) begin
                     status = ST_ZERO_CHUNK;
                  end else if (too_big) begin
                     status = ST_EXCEEDS;
                  end else begin
                     ended    = 1'b0;
                     phase_in = PH_DATA;
                     drem_in  = cur_acc;
                  end
               end else begin
                  // a held cr not followed by lf ends the digits
                  if (cur_pcr) begin
                     pcr_in = 1'b0;
                     if (cur_phase == PH_SIZE && cur_pfx != PFX_START) begin
                        ph_mid = PH_TAIL;
                     end
                  end
                  phase_in = ph_mid;
                  if (it_cls.is_cr) begin
                     pcr_in = 1'b1;
                  end else if (ph_mid == PH_SIZE) begin
                     case (cur_pfx)
                        PFX_START: begin
                           if (it_cls.is_blank) begin
                              phase_in = PH_SIZE;
                           end else if (it_cls.is_zero) begin
                              digit_in = 1'b1;
                              acc_in   = '0;
                              pfx_in   = PFX_ZERO;
                           end else if (it_cls.is_hex) begin
                              ovf_in   = cur_ovf | acc_carry;
                              acc_in   = acc_shift;
                              digit_in = 1'b1;
                              pfx_in   = PFX_DIGITS;
                           end else begin
                              phase_in = PH_TAIL;
                           end
                        end
                        PFX_ZERO: begin
                           if (it_cls.is_x) begin
                              pfx_in = PFX_X;
                           end else if (it_cls.is_hex) begin
                              ovf_in   = cur_ovf | acc_carry;
                              acc_in   = acc_shift;
                              digit_in = 1'b1;
                              pfx_in   = PFX_DIGITS;
                           end else begin
                              phase_in = PH_TAIL;
                           end
                        end
                        default: begin
                           if (it_cls.is_hex) begin
                              ovf_in   = cur_ovf | acc_carry;
                              acc_in   = acc_shift;
                              digit_in = 1'b1;
                              pfx_in   = PFX_DIGITS;
                           end else begin
                              phase_in = PH_TAIL;
                           end
                        end
                     endcase
                  end
                  if (fin) begin
                     ended  = 1'b1;
                     status = ST_IN_LINE;
                  end
               end
            end
            PH_DATA: begin
               pos_in  = pos_next;
               valid   = 1'b1;
               drem_in = drem_dec;
               if (drem_dec == '0) begin
                  phase_in = PH_SKIP;
                  srem_in  = 2'd2;
               end
               if (fin) begin
                  ended  = 1'b1;
                  status = ST_BOUNDARY;
               end
            end
            default: begin
               // two bytes after the data are skipped
               pos_in  = pos_next;
               srem_in = srem_dec;
               if (srem_dec == 2'd0) begin
                  phase_in = PH_SIZE;
                  acc_in   = '0;
                  ovf_in   = 1'b0;
                  digit_in = 1'b0;
                  pfx_in   = PFX_START;
                  pcr_in   = 1'b0;
               end
               if (fin) begin
                  ended  = 1'b1;
                  status = ST_BOUNDARY;
               end
            end
         endcase

         if (ended) begin
            phase_in = it_last ? PH_IDLE : PH_DONE;
         end

         if (valid || ended) begin
            rsp_valid_in               = 1'b1;
            rsp_word_in.out_byte       = valid ? it_byte : 8'h00;
            rsp_word_in.byte_valid     = valid;
            rsp_word_in.end_of_message = ended;
            rsp_word_in.end_status     = ended ? status : ST_ZERO_CHUNK;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         len_ff       <= '0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         digit_ff     <= 1'b0;
         pfx_ff       <= PFX_START;
         pcr_ff       <= 1'b0;
         drem_ff      <= '0;
         srem_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         digit_ff     <= digit_in;
         pfx_ff       <= pfx_in;
         pcr_ff       <= pcr_in;
         drem_ff      <= drem_in;
         srem_ff      <= srem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ rtl/http_chunked_body_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Chunked transfer body decoder, one body byte per word.
// ----------------------------------------------------------------------------
// Takes one body byte per clock cycle while the queue has room and delivers
// decoded payload bytes and one end-of-message word with a status per body. A
// byte enters the front part, which classifies it and writes it into a
// two-entry queue; the back part reads one queued word per cycle while the
// output register is free or drained, updates the chunk state and loads the
// output register. The sustained rate is one byte per cycle without stalls, set
// by the back part's single state update per cycle. Bytes that produce no
// result are consumed without an output word. The queue and the output
// register let either side stall without stopping the other at once.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit
   import chdec_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_first_byte,
   input  logic                   req_last_byte,
   input  logic [LENGTH_BITS-1:0] req_body_length,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_end_of_message,
   output logic [2:0]             rsp_end_status
);

   localparam int unsigned ITEM_BITS = CLASS_BITS + 8 + 2 + LENGTH_BITS;

   logic                 q_push;
   logic                 q_pop;
   logic                 q_full;
   logic                 q_not_empty;
   logic [ITEM_BITS-1:0] q_in_item;
   logic [ITEM_BITS-1:0] q_head_item;
   result_type           rsp_word;

   // front: accept and classify
   chdec_front #(
      .LENGTH_BITS (LENGTH_BITS),
      .ITEM_BITS   (ITEM_BITS)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .req_body_length (req_body_length),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_in_item)
   );

   // queue between the two parts
   chdec_queue #(
      .WIDTH (ITEM_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_item),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head_data (q_head_item)
   );

   // back: chunk decode and output register
   chdec_back #(
      .LENGTH_BITS (LENGTH_BITS),
      .ITEM_BITS   (ITEM_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_item      (q_head_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

   assign rsp_out_byte       = rsp_word.out_byte;
   assign rsp_byte_valid     = rsp_word.byte_valid;
   assign rsp_end_of_message = rsp_word.end_of_message;
   assign rsp_end_status     = rsp_word.end_status;

endmodule
